// ----- hdl/tgbd_pkg.sv -----
// ----------------------------------------------------------------------------
// tgbd_pkg
// shared types, codes and widths for the graphics byte decoder
// ----------------------------------------------------------------------------
package tgbd_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 13;
    localparam int PROD_BITS  = COORD_BITS + CFG_BITS;
    localparam int SX_BITS    = 13;
    localparam int SY_BITS    = 14;
    localparam int CNT_BITS   = $clog2(PROD_BITS + 1);

    // display modes
    localparam logic [2:0] MODE_ALPHA   = 3'd0;
    localparam logic [2:0] MODE_VECTOR  = 3'd1;
    localparam logic [2:0] MODE_MARKER  = 3'd2;
    localparam logic [2:0] MODE_PLOT    = 3'd3;
    localparam logic [2:0] MODE_UNKNOWN = 3'd4;

    // actions
    localparam logic [2:0] ACT_MOVE = 3'd0;
    localparam logic [2:0] ACT_DRAW = 3'd1;
    localparam logic [2:0] ACT_MARK = 3'd2;
    localparam logic [2:0] ACT_PASS = 3'd3;
    localparam logic [2:0] ACT_BEEP = 3'd4;
    localparam logic [2:0] ACT_VT   = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SIMPLE = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_VIEW_W   = 3'd2;
    localparam logic [2:0] REG_VIEW_H   = 3'd3;
    localparam logic [2:0] REG_BEEP     = 3'd4;
    localparam logic [2:0] REG_AUTO_VT  = 3'd5;

    // control bytes
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_HT  = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_FS  = 8'h1c;
    localparam logic [7:0] CH_GS  = 8'h1d;
    localparam logic [7:0] CH_RS  = 8'h1e;
    localparam logic [7:0] CH_US  = 8'h1f;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LOX = 8'h40;
    localparam logic [7:0] CH_LOY = 8'h60;
    localparam logic [7:0] CH_DEL = 8'h7f;
    localparam logic [7:0] CH_P   = 8'h50;

    typedef struct packed {
        logic [CFG_BITS-1:0] screen_w;
        logic [CFG_BITS-1:0] screen_h;
        logic [CFG_BITS-1:0] view_w;
        logic [CFG_BITS-1:0] view_h;
        logic                beep_en;
        logic                auto_vt;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_start;
        logic div_sel_y;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       div_done;
    } status_t;

endpackage

// ----- hdl/tgbd_div.sv -----
// ----------------------------------------------------------------------------
// tgbd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tgbd_div
    import tgbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROD_BITS-1:0] dividend,
    input  logic [CFG_BITS-1:0]  divisor,
    output logic                 done,
    output logic [PROD_BITS-1:0] quotient
);

    logic [PROD_BITS-1:0] dq_reg, dq_next;
    logic [CFG_BITS:0]    rem_reg, rem_next;
    logic [CFG_BITS-1:0]  div_reg, div_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CFG_BITS:0]    trial;
    logic                 qbit;

    always_comb
    begin
        trial     = {rem_reg[CFG_BITS-1:0], dq_reg[PROD_BITS-1]};
        qbit      = (trial >= {1'b0, div_reg});
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_BITS'(PROD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? (trial - {1'b0, div_reg}) : trial;
            dq_next  = {dq_reg[PROD_BITS-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- hdl/tgbd_datapath.sv -----
// ----------------------------------------------------------------------------
// tgbd_datapath
// byte decode, decoder state, scaling and the output word register
// ----------------------------------------------------------------------------
module tgbd_datapath
    import tgbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    input  logic [7:0]  in_byte,
    output status_t     status,
    output logic [63:0] out_word
);

    logic [2:0] mode_reg, mode_next;
    logic       mp_reg, mp_next, mk_reg, mk_next, aa_reg, aa_next;
    logic       pen_reg, pen_next, rs_reg, rs_next;
    logic [1:0] lc_reg, lc_next;
    logic [4:0] lprev_reg, lprev_next, llast_reg, llast_next;
    logic [4:0] hx_reg, hx_next, hy_reg, hy_next, ly_reg, ly_next, ex_reg, ex_next;
    logic [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic [1:0] kind;
    logic [2:0] act;
    logic [7:0] pass;
    logic [2:0] act_reg;
    logic [7:0] pass_reg;
    logic [1:0] kind_reg;
    logic [PROD_BITS-1:0] prodx_reg, prody_reg, qx_reg, quot;
    logic [CFG_BITS-1:0]  vw_nz, vh_nz;
    logic                 div_done;
    logic [63:0]          word_reg;
    logic [SX_BITS-1:0]   sx;
    logic signed [PROD_BITS+1:0] sy_full;
    logic [SY_BITS-1:0]   sy;

    function automatic logic [COORD_BITS-1:0] clamp_step(
        input logic [COORD_BITS-1:0] p,
        input logic [1:0]            dir,
        input logic [CFG_BITS-1:0]   span_nz
    );
        logic signed [COORD_BITS+1:0] v;
        logic signed [COORD_BITS+1:0] hi;
        begin
            hi = $signed({1'b0, span_nz}) - (COORD_BITS+2)'(1);
            if (hi > $signed((COORD_BITS+2)'((1 << COORD_BITS) - 1)))
                hi = $signed((COORD_BITS+2)'((1 << COORD_BITS) - 1));
            v = $signed({2'b00, p});
            if (dir == 2'd1)
                v = v + (COORD_BITS+2)'(4);
            else if (dir == 2'd2)
                v = v - (COORD_BITS+2)'(4);
            if (v > hi)
                v = hi;
            if (v < 0)
                v = '0;
            clamp_step = v[COORD_BITS-1:0];
        end
    endfunction

    function automatic logic graphic_ignored(input logic [7:0] b);
        begin
            graphic_ignored = (b <= 8'h06) || (b >= 8'h08 && b <= 8'h0c) ||
                              (b >= 8'h0e && b <= 8'h17) || b == 8'h19 ||
                              b == 8'h1a || b[7];
        end
    endfunction

    function automatic logic [63:0] out_next();
        begin
            if (kind_reg == KIND_POINT)
                out_next = {2'b00, 8'h00, sy, sx, py_reg, px_reg, act_reg};
            else
                out_next = {2'b00, (act_reg == ACT_PASS) ? pass_reg : 8'h00,
                            51'd0, act_reg};
        end
    endfunction

    assign vw_nz = (cfg.view_w == '0) ? CFG_BITS'(1) : cfg.view_w;
    assign vh_nz = (cfg.view_h == '0) ? CFG_BITS'(1) : cfg.view_h;

    always_comb
    begin
        logic [1:0] dx, dy;
        logic       step_ok;
        mode_next  = mode_reg;
        mp_next    = mp_reg;
        mk_next    = mk_reg;
        aa_next    = aa_reg;
        pen_next   = pen_reg;
        rs_next    = rs_reg;
        lc_next    = lc_reg;
        lprev_next = lprev_reg;
        llast_next = llast_reg;
        hx_next    = hx_reg;
        hy_next    = hy_reg;
        ly_next    = ly_reg;
        ex_next    = ex_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        kind       = KIND_NONE;
        act        = ACT_PASS;
        pass       = 8'h00;
        dx         = 2'd0;
        dy         = 2'd0;
        step_ok    = 1'b1;
        if (mode_reg >= MODE_UNKNOWN)
        begin
            if (in_byte == CH_US)
            begin
                mode_next = MODE_ALPHA;
                aa_next   = 1'b0;
            end
        end
        else if (in_byte == CH_CAN)
        begin
            if (cfg.auto_vt)
            begin
                kind = KIND_SIMPLE;
                act  = ACT_VT;
            end
        end
        else if (in_byte == CH_ESC)
        begin
            kind = KIND_SIMPLE;
            pass = in_byte;
        end
        else if (in_byte == CH_FS || in_byte == CH_GS)
        begin
            mp_next   = 1'b1;
            aa_next   = 1'b0;
            mode_next = (in_byte == CH_FS) ? MODE_MARKER : MODE_VECTOR;
        end
        else if (in_byte == CH_RS)
        begin
            mode_next = MODE_PLOT;
            rs_next   = 1'b1;
        end
        else if (mode_reg == MODE_ALPHA)
        begin
            if (in_byte == CH_BEL)
            begin
                if (cfg.beep_en)
                begin
                    kind = KIND_SIMPLE;
                    act  = ACT_BEEP;
                end
            end
            else if (in_byte == CH_BS || in_byte == CH_HT || in_byte == CH_LF ||
                     in_byte == CH_CR || (in_byte >= CH_SP && in_byte != CH_DEL))
            begin
                kind = KIND_SIMPLE;
                pass = in_byte;
            end
        end
        else if (in_byte == CH_BEL)
        begin
            if ((mode_reg == MODE_VECTOR || mode_reg == MODE_MARKER) && mp_reg)
                mp_next = 1'b0;
            else if (cfg.beep_en)
            begin
                kind = KIND_SIMPLE;
                act  = ACT_BEEP;
            end
        end
        else if (in_byte == CH_CR)
        begin
            mode_next = MODE_ALPHA;
            aa_next   = 1'b0;
            kind      = KIND_SIMPLE;
            pass      = in_byte;
        end
        else if (in_byte == CH_US)
        begin
            mode_next = MODE_ALPHA;
            aa_next   = 1'b0;
        end
        else if (graphic_ignored(in_byte))
        begin
            kind = KIND_NONE;
        end
        else if (mode_reg == MODE_PLOT)
        begin
            if (in_byte == CH_DEL)
                kind = KIND_NONE;
            else if (rs_reg)
            begin
                rs_next = 1'b0;
                if (in_byte == CH_SP)
                    pen_next = 1'b0;
                else if (in_byte == CH_P)
                    pen_next = 1'b1;
                else
                    mode_next = MODE_UNKNOWN;
            end
            else
            begin
                // dir code: 1 up by four, 2 down by four
                case (in_byte)
                    8'h41: dx = 2'd1;
                    8'h42: dx = 2'd2;
                    8'h44: dy = 2'd1;
                    8'h45: begin dx = 2'd1; dy = 2'd1; end
                    8'h46: begin dx = 2'd2; dy = 2'd1; end
                    8'h48: dy = 2'd2;
                    8'h49: begin dx = 2'd1; dy = 2'd2; end
                    8'h4a: begin dx = 2'd2; dy = 2'd2; end
                    default: step_ok = 1'b0;
                endcase
                if (step_ok)
                begin
                    px_next = clamp_step(px_reg, dx, vw_nz);
                    py_next = clamp_step(py_reg, dy, vh_nz);
                    kind    = KIND_POINT;
                    act     = pen_reg ? ACT_DRAW : ACT_MOVE;
                end
            end
        end
        else
        begin
            if (!aa_reg)
            begin
                lc_next = 2'd0;
                aa_next = 1'b1;
                if (mode_reg == MODE_MARKER)
                begin
                    mp_next = 1'b1;
                    mk_next = 1'b1;
                end
                else
                    mk_next = 1'b0;
            end
            if (in_byte < CH_LOX)
            begin
                if (lc_next == 2'd0)
                    hy_next = in_byte[4:0];
                else
                    hx_next = in_byte[4:0];
            end
            else if (in_byte >= CH_LOY)
            begin
                lprev_next = llast_reg;
                llast_next = in_byte[4:0];
                if (lc_next < 2'd2)
                    lc_next = lc_next + 2'd1;
            end
            else
            begin
                aa_next = 1'b0;
                if (lc_next > 2'd1)
                    ex_next = lprev_reg;
                if (lc_next > 2'd0)
                    ly_next = llast_reg;
                px_next = {hx_next, in_byte[4:0], ex_next[1:0]};
                py_next = {hy_next, ly_next, ex_next[3:2]};
                kind    = KIND_POINT;
                if (mk_next)
                    act = ACT_MARK;
                else
                    act = mp_next ? ACT_MOVE : ACT_DRAW;
                mp_next = 1'b0;
                mk_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ALPHA;
            mp_reg    <= 1'b0;
            mk_reg    <= 1'b0;
            aa_reg    <= 1'b0;
            pen_reg   <= 1'b0;
            rs_reg    <= 1'b0;
            lc_reg    <= 2'd0;
            lprev_reg <= '0;
            llast_reg <= '0;
            hx_reg    <= '0;
            hy_reg    <= '0;
            ly_reg    <= '0;
            ex_reg    <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            kind_reg  <= KIND_NONE;
        end
        else if (cmd.accept)
        begin
            mode_reg  <= mode_next;
            mp_reg    <= mp_next;
            mk_reg    <= mk_next;
            aa_reg    <= aa_next;
            pen_reg   <= pen_next;
            rs_reg    <= rs_next;
            lc_reg    <= lc_next;
            lprev_reg <= lprev_next;
            llast_reg <= llast_next;
            hx_reg    <= hx_next;
            hy_reg    <= hy_next;
            ly_reg    <= ly_next;
            ex_reg    <= ex_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            kind_reg  <= kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg  <= act;
            pass_reg <= pass;
        end
        if (cmd.mul)
        begin
            prodx_reg <= PROD_BITS'(px_reg) * PROD_BITS'(cfg.screen_w);
            prody_reg <= PROD_BITS'(py_reg) * PROD_BITS'(cfg.screen_h);
        end
        // x quotient is ready in the cycle that starts the y division
        if (div_done && cmd.div_start)
            qx_reg <= quot;
        if (cmd.emit)
            word_reg <= out_next();
    end

    tgbd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_y ? prody_reg : prodx_reg),
        .divisor  (cmd.div_sel_y ? vh_nz : vw_nz),
        .done     (div_done),
        .quotient (quot)
    );

    // saturate scaled coordinates
    always_comb
    begin
        sx = (qx_reg > PROD_BITS'((1 << SX_BITS) - 1)) ? {SX_BITS{1'b1}}
                                                      : qx_reg[SX_BITS-1:0];
        sy_full = (PROD_BITS+2)'($signed({2'b00, PROD_BITS'(cfg.screen_h)})
                  - $signed((PROD_BITS+2)'(1)) - $signed({2'b00, quot}));
        if (sy_full > $signed((PROD_BITS+2)'((1 << (SY_BITS - 1)) - 1)))
            sy = {1'b0, {(SY_BITS-1){1'b1}}};
        else if (sy_full < -$signed((PROD_BITS+2)'(1 << (SY_BITS - 1))))
            sy = {1'b1, {(SY_BITS-1){1'b0}}};
        else
            sy = sy_full[SY_BITS-1:0];
    end

    assign status.kind     = kind;
    assign status.div_done = div_done;
    assign out_word        = word_reg;

endmodule

// ----- hdl/tgbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// tgbd_ctrl
// sequencer: accept, multiply, two divisions, output handoff
// ----------------------------------------------------------------------------
module tgbd_ctrl
    import tgbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIVX = 3'd2;
    localparam logic [2:0] S_DIVY = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       slot_free;
    // the x division starts on the first cycle after the multiply
    logic       mul_d_reg;

    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        ov_next       = ov_reg && !out_ready;
        cmd           = '0;
        cmd.accept    = (state_reg == S_IDLE) && in_valid;
        cmd.div_sel_y = (state_reg == S_DIVY);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.kind == KIND_POINT)
                        state_next = S_MUL;
                    else if (status.kind == KIND_SIMPLE)
                        state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVX;
            end
            S_DIVX:
            begin
                cmd.div_start = mul_d_reg;
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel_y = 1'b1;
                    state_next    = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (status.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            mul_d_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            mul_d_reg <= (state_reg == S_MUL);
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

endmodule

// ----- hdl/tek_graphics_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// tek_graphics_byte_decoder
// graphics terminal byte decoder with screen scaling
// ----------------------------------------------------------------------------
// s_axis carries one received terminal byte per word in s_tdata[7:0].
// m_axis carries one result word per byte that produces one: action, terminal
// x/y, scaled screen x/y and a passed-on byte. Bytes that cause no result
// only update the decoder state.
// A byte that gives no result frees the input on the next cycle. A simple
// result (pass, beep, switch to vt) goes from the emit state into the output
// register once it is free, and the next byte is taken after that.
// A byte that completes a point passes through a multiply, the start of the x
// division, then two 25-step serial divisions on the shared divider (x then
// y), each closed by a done strobe, and the emit into the output register
// before the next byte is taken.
// The result sits in an output register, so a stalled m_tready does not
// block the next byte; only the following result waits for the register.
// Reset clears the mode to alpha, the address state, the point and the output
// valid flag, and loads the default screen and view sizes. The user must write
// registers over the apb port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tek_graphics_byte_decoder
    import tgbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // action[2:0] tek_x[14:3] tek_y[26:15] screen_x[39:27] screen_y[53:40]
    // pass_byte[61:54] zero[63:62]
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_SCREEN_W: cfg_next.screen_w = pwdata[CFG_BITS-1:0];
                REG_SCREEN_H: cfg_next.screen_h = pwdata[CFG_BITS-1:0];
                REG_VIEW_W:   cfg_next.view_w   = pwdata[CFG_BITS-1:0];
                REG_VIEW_H:   cfg_next.view_h   = pwdata[CFG_BITS-1:0];
                REG_BEEP:     cfg_next.beep_en  = pwdata[0];
                REG_AUTO_VT:  cfg_next.auto_vt  = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SCREEN_W: prdata = 32'(cfg_reg.screen_w);
            REG_SCREEN_H: prdata = 32'(cfg_reg.screen_h);
            REG_VIEW_W:   prdata = 32'(cfg_reg.view_w);
            REG_VIEW_H:   prdata = 32'(cfg_reg.view_h);
            REG_BEEP:     prdata = 32'(cfg_reg.beep_en);
            REG_AUTO_VT:  prdata = 32'(cfg_reg.auto_vt);
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_w <= CFG_BITS'(1024);
            cfg_reg.screen_h <= CFG_BITS'(780);
            cfg_reg.view_w   <= CFG_BITS'(4096);
            cfg_reg.view_h   <= CFG_BITS'(3120);
            cfg_reg.beep_en  <= 1'b1;
            cfg_reg.auto_vt  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tgbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tgbd_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .in_byte  (s_tdata),
        .status   (status),
        .out_word (m_tdata)
    );

    a_div_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> !s_tready)
        else $error("divider finished while idle");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ACT_VT)
        else $error("action code out of range");

    a_pass_no_coord: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] == ACT_PASS) |-> m_tdata[53:3] == '0)
        else $error("pass word carries coordinates");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !cmd.emit)
        else $error("output overwritten while stalled");

endmodule

// ----- test/tek_graphics_byte_decoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tek_graphics_byte_decoder_test
// self-checking bench for the graphics terminal byte decoder
// ----------------------------------------------------------------------------
// Bytes go in on the slave stream and results come out on the master stream.
// A local decoder model predicts every result word, and a monitor checks
// each word field by field against the oldest prediction. Directed bytes
// cover the modes, the controls and the address extremes. Runs of well-formed
// address and plot sequences with random content follow, mixed with noise,
// under several register settings. Both streams stall in random bursts.
// ----------------------------------------------------------------------------
module tek_graphics_byte_decoder_test;
    import tgbd_pkg::*;

    typedef struct {
        logic [2:0]  act;
        logic [11:0] tx;
        logic [11:0] ty;
        logic [12:0] sx;
        logic [13:0] sy;
        logic [7:0]  pb;
    } result_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tek_graphics_byte_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    result_word_t pending_words[$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    bit           quiet;

    // decoder model state
    logic [12:0] cfg_sw, cfg_sh, cfg_vw, cfg_vh;
    logic        cfg_beep, cfg_vt;
    logic [2:0]  mode;
    bit          mv_pend, mk_pend, addr_on, pen, rs_seen;
    int unsigned lo_cnt, lo_prev, lo_last, hi_x, hi_y, lo_y, extra;
    int unsigned px, py;

    logic [7:0] plot_dirs[8] = '{8'h41, 8'h42, 8'h44, 8'h45, 8'h46, 8'h48, 8'h49, 8'h4a};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned nz(input logic [12:0] v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic result_word_t simple_word(input logic [2:0] act, input logic [7:0] b);
        result_word_t w;
        w = '{act: act, tx: 0, ty: 0, sx: 0, sy: 0, pb: (act == ACT_PASS) ? b : 8'h00};
        return w;
    endfunction

    function automatic result_word_t point_word(input logic [2:0] act);
        result_word_t w;
        longint unsigned sxl;
        longint          syl;
        sxl = (longint'(px) * cfg_sw) / nz(cfg_vw);
        syl = longint'(cfg_sh) - 1 - longint'((longint'(py) * cfg_sh) / nz(cfg_vh));
        if (sxl > 8191) sxl = 8191;
        if (syl > 8191) syl = 8191;
        if (syl < -8192) syl = -8192;
        w.act = act;
        w.tx  = px[11:0];
        w.ty  = py[11:0];
        w.sx  = sxl[12:0];
        w.sy  = syl[13:0];
        w.pb  = 8'h00;
        return w;
    endfunction

    function automatic int unsigned clamp_step(input int unsigned p, input int d,
                                               input logic [12:0] span);
        longint v;
        longint hi;
        v  = longint'(p) + d;
        hi = longint'(nz(span)) - 1;
        if (hi > 4095) hi = 4095;
        if (v > hi) v = hi;
        if (v < 0) v = 0;
        return int'(v);
    endfunction

    function automatic bit graphic_ignored(input logic [7:0] b);
        return b <= 8'h06 || (b >= 8'h08 && b <= 8'h0c) || (b >= 8'h0e && b <= 8'h17) ||
               b == 8'h19 || b == 8'h1a || b >= 8'h80;
    endfunction

    task automatic enter_alpha();
        mode    = MODE_ALPHA;
        addr_on = 0;
    endtask

    task automatic beep_word(output bit got, output result_word_t w);
        got = cfg_beep;
        w   = simple_word(ACT_BEEP, 8'h00);
    endtask

    // address byte in vector or marker mode
    task automatic decode_address(input logic [7:0] b, output bit got, output result_word_t w);
        int unsigned x, y;
        got = 0;
        if (!addr_on)
        begin
            lo_cnt  = 0;
            addr_on = 1;
            if (mode == MODE_MARKER)
            begin
                mv_pend = 1;
                mk_pend = 1;
            end
            else
                mk_pend = 0;
        end
        if (b < 8'h40)
        begin
            if (lo_cnt == 0) hi_y = b - 8'h20;
            else hi_x = b - 8'h20;
        end
        else if (b >= 8'h60)
        begin
            lo_prev = lo_last;
            lo_last = b - 8'h60;
            if (lo_cnt < 2) lo_cnt++;
        end
        else
        begin
            addr_on = 0;
            if (lo_cnt > 1) extra = lo_prev;
            if (lo_cnt > 0) lo_y = lo_last;
            x  = hi_x * 128 + (b - 8'h40) * 4 + (extra & 3);
            y  = hi_y * 128 + lo_y * 4 + ((extra >> 2) & 3);
            px = x & 12'hfff;
            py = y & 12'hfff;
            got = 1;
            w = point_word(mk_pend ? ACT_MARK : (mv_pend ? ACT_MOVE : ACT_DRAW));
            mv_pend = 0;
            mk_pend = 0;
        end
    endtask

    task automatic decode_plot(input logic [7:0] b, output bit got, output result_word_t w);
        int dx, dy;
        dx  = 0;
        dy  = 0;
        got = 1;
        case (b)
            8'h41: dx = 4;
            8'h42: dx = -4;
            8'h44: dy = 4;
            8'h45: begin dx = 4; dy = 4; end
            8'h46: begin dx = -4; dy = 4; end
            8'h48: dy = -4;
            8'h49: begin dx = 4; dy = -4; end
            8'h4a: begin dx = -4; dy = -4; end
            default: got = 0;
        endcase
        if (got)
        begin
            px = clamp_step(px, dx, cfg_vw);
            py = clamp_step(py, dy, cfg_vh);
            w  = point_word(pen ? ACT_DRAW : ACT_MOVE);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, output bit got, output result_word_t w);
        got = 0;
        w   = simple_word(ACT_PASS, 8'h00);
        if (mode >= MODE_UNKNOWN)
        begin
            if (b == CH_US) enter_alpha();
        end
        else if (b == CH_CAN)
        begin
            got = cfg_vt;
            w   = simple_word(ACT_VT, 8'h00);
        end
        else if (b == CH_ESC)
        begin
            got = 1;
            w   = simple_word(ACT_PASS, b);
        end
        else if (b == CH_FS || b == CH_GS)
        begin
            mv_pend = 1;
            addr_on = 0;
            mode    = (b == CH_FS) ? MODE_MARKER : MODE_VECTOR;
        end
        else if (b == CH_RS)
        begin
            mode    = MODE_PLOT;
            rs_seen = 1;
        end
        else if (mode == MODE_ALPHA)
        begin
            if (b == CH_BEL)
                beep_word(got, w);
            else if (b == CH_BS || b == CH_HT || b == CH_LF || b == CH_CR ||
                     (b >= CH_SP && b != CH_DEL))
            begin
                got = 1;
                w   = simple_word(ACT_PASS, b);
            end
        end
        else if (b == CH_BEL)
        begin
            if ((mode == MODE_VECTOR || mode == MODE_MARKER) && mv_pend)
                mv_pend = 0;
            else
                beep_word(got, w);
        end
        else if (b == CH_CR)
        begin
            enter_alpha();
            got = 1;
            w   = simple_word(ACT_PASS, b);
        end
        else if (b == CH_US)
            enter_alpha();
        else if (graphic_ignored(b))
            got = 0;
        else if (mode == MODE_PLOT)
        begin
            if (b == CH_DEL)
                got = 0;
            else if (rs_seen)
            begin
                if (b == CH_SP) pen = 0;
                else if (b == CH_P) pen = 1;
                else mode = MODE_UNKNOWN;
                rs_seen = 0;
            end
            else
                decode_plot(b, got, w);
        end
        else
            decode_address(b, got, w);
    endtask

    // sender side
    task automatic send_byte(input logic [7:0] b);
        bit           rdy;
        bit           got;
        result_word_t w;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        decode_byte(b, got, w);
        if (got) pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [12:0] sw, input logic [12:0] sh,
                              input logic [12:0] vw, input logic [12:0] vh,
                              input logic be, input logic av);
        wait_drained();
        apb_write(REG_SCREEN_W, 32'(sw));
        apb_write(REG_SCREEN_H, 32'(sh));
        apb_write(REG_VIEW_W, 32'(vw));
        apb_write(REG_VIEW_H, 32'(vh));
        apb_write(REG_BEEP, 32'(be));
        apb_write(REG_AUTO_VT, 32'(av));
        cfg_sw   = sw;
        cfg_sh   = sh;
        cfg_vw   = vw;
        cfg_vh   = vh;
        cfg_beep = be;
        cfg_vt   = av;
    endtask

    // one random run of bytes, mostly well-formed sequences
    task automatic send_random_run(inout int unsigned sent);
        logic [7:0] ctl[9] = '{CH_BEL, CH_CAN, CH_ESC, CH_CR, CH_US, CH_LF, CH_BS, CH_HT, CH_DEL};
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte($urandom_range(0, 1) ? CH_GS : CH_FS);
                    sent++;
                end
                if ($urandom_range(0, 1))
                begin
                    send_byte(8'(8'h20 + $urandom_range(0, 31)));
                    sent++;
                end
                if ($urandom_range(0, 1))
                begin
                    send_byte(8'(8'h60 + $urandom_range(0, 31)));
                    sent++;
                end
                if ($urandom_range(0, 1))
                begin
                    send_byte(8'(8'h60 + $urandom_range(0, 31)));
                    sent++;
                end
                if ($urandom_range(0, 1))
                begin
                    send_byte(8'(8'h20 + $urandom_range(0, 31)));
                    sent++;
                end
                send_byte(8'(8'h40 + $urandom_range(0, 31)));
                sent++;
            end
            4, 5:
            begin
                send_byte(CH_RS);
                send_byte($urandom_range(0, 1) ? CH_SP : CH_P);
                sent += 2;
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                          : plot_dirs[$urandom_range(0, 7)]);
                    sent++;
                end
            end
            6:
            begin
                send_byte(ctl[$urandom_range(0, 8)]);
                sent++;
            end
            7:
            begin
                send_byte(CH_US);
                sent++;
                repeat ($urandom_range(1, 3))
                begin
                    send_byte(8'($urandom_range(8'h20, 8'hff)));
                    sent++;
                end
            end
            8:
            begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
            default:
            begin
                send_byte(CH_RS);
                send_byte(8'($urandom_range(8'h21, 8'h4f)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(CH_ESC);
                send_byte(CH_US);
                sent += 5;
            end
        endcase
    endtask

    task automatic test_directed();
        logic [7:0] seq[] = '{8'h41, 8'hff, CH_BEL, CH_CAN, CH_ESC, CH_LF, 8'h00,
                             CH_GS, 8'h3f, 8'h7f, 8'h7f, 8'h3f, 8'h5f,
                             8'h20, 8'h60, 8'h40, CH_BEL, CH_DEL, 8'h80, 8'h45,
                             CH_FS, CH_BEL, 8'h52, CH_CR,
                             CH_RS, CH_P, 8'h42, 8'h4a, 8'h41, 8'h43,
                             CH_RS, 8'h5a, CH_ESC, CH_GS, CH_US, CH_BEL};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_random(input int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count) send_random_run(sent);
    endtask

    task automatic test_settings();
        set_config(13'd1, 13'd1, 13'd1, 13'd1, 1'b0, 1'b1);
        test_random(40);
        set_config(13'd4096, 13'd4096, 13'd4096, 13'd4096, 1'b1, 1'b1);
        test_random(40);
        set_config(13'd8191, 13'd8191, 13'd16, 13'd12, 1'b0, 1'b0);
        test_random(40);
        set_config(13'd640, 13'd480, 13'd0, 13'd0, 1'b1, 1'b1);
        test_random(40);
        set_config(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        test_random(60);
    endtask

    task automatic test_drain_pause();
        test_random(20);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        @(posedge clk);
        test_random(20);
    endtask

    task automatic test_no_idle();
        set_config(13'd1024, 13'd780, 13'd4096, 13'd3120, 1'b1, 1'b0);
        quiet = 1;
        test_random(100);
    endtask

    // receiver stalls
    int unsigned stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                error_count++;
            end
            else
            begin
                result_word_t w;
                w = pending_words.pop_front();
                if (m_tdata[2:0] !== w.act)
                begin
                    $error("action expected %0d actual %0d", w.act, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[14:3] !== w.tx)
                begin
                    $error("tek_x expected %0d actual %0d", w.tx, m_tdata[14:3]);
                    error_count++;
                end
                if (m_tdata[26:15] !== w.ty)
                begin
                    $error("tek_y expected %0d actual %0d", w.ty, m_tdata[26:15]);
                    error_count++;
                end
                if (m_tdata[39:27] !== w.sx)
                begin
                    $error("screen_x expected %0d actual %0d", w.sx, m_tdata[39:27]);
                    error_count++;
                end
                if (m_tdata[53:40] !== w.sy)
                begin
                    $error("screen_y expected %0d actual %0d", $signed(w.sy),
                           $signed(m_tdata[53:40]));
                    error_count++;
                end
                if (m_tdata[61:54] !== w.pb)
                begin
                    $error("pass_byte expected %h actual %h", w.pb, m_tdata[61:54]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        quiet       = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cfg_sw = 13'd1024; cfg_sh = 13'd780; cfg_vw = 13'd4096; cfg_vh = 13'd3120;
        cfg_beep = 1'b1; cfg_vt = 1'b0;
        mode = MODE_ALPHA;
        mv_pend = 0; mk_pend = 0; addr_on = 0; pen = 0; rs_seen = 0;
        lo_cnt = 0; lo_prev = 0; lo_last = 0; hi_x = 0; hi_y = 0; lo_y = 0; extra = 0;
        px = 0; py = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random(60);
        test_drain_pause();
        test_settings();
        test_no_idle();
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
